// File: sv/buzzer_pattern_sequencer_unit_assert.svh
// assertion helpers for the buzzer pattern sequencer
`ifndef BUZZER_PATTERN_SEQUENCER_UNIT_ASSERT_SVH
`define BUZZER_PATTERN_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buzzer sequencer assertion failed");

// next-cycle implication, checked out of reset
`define BPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buzzer sequencer assertion failed");

`endif

// File: sv/bps_pkg.sv
`timescale 1ns / 1ps

package bps_pkg;

   localparam int TIME_WIDTH = 16;
   localparam int REG_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [REG_WIDTH-1:0] CLICK_LENGTH_RESET      = 16'd50;
   localparam logic [REG_WIDTH-1:0] ALARM_HALF_PERIOD_RESET = 16'd200;
   localparam logic [REG_WIDTH-1:0] ALARM_LIMIT_RESET       = 16'd60000;
   localparam logic [REG_WIDTH-1:0] DONE_LENGTH_RESET       = 16'd2000;
   localparam logic [REG_WIDTH-1:0] NOTIFY_STEP_RESET       = 16'd100;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_PLAY = 2'd1,
      CMD_STOP = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      PAT_OFF    = 3'd0,
      PAT_CLICK  = 3'd1,
      PAT_ALARM  = 3'd2,
      PAT_DONE   = 3'd3,
      PAT_NOTIFY = 3'd4
   } pattern_type;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_GAP    = 2'd1,
      PH_SECOND = 2'd2
   } phase_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_CLICK_LENGTH      = 3'd0,
      REG_ALARM_HALF_PERIOD = 3'd1,
      REG_ALARM_LIMIT       = 3'd2,
      REG_DONE_LENGTH       = 3'd3,
      REG_NOTIFY_STEP       = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic sound_enable;
      logic busy_res;
   } result_type;

endpackage

// File: sv/buzzer_pattern_sequencer_unit.sv
`timescale 1ns / 1ps
`include "buzzer_pattern_sequencer_unit_assert.svh"

// channel   | direction | payload                   | handshake
// req_      | in        | command, pattern          | req_valid / req_stall
// rsp_      | out       | sound_enable, busy_res    | rsp_valid / rsp_stall
// csr_      | in        | index, wdata (16 bits)    | csr_write, no wait
//
// one beat per cycle while req_stall is low; the pattern state updates at the accepting edge and
// the result is registered in the output register, or in the skid entry while the output beat is held.
// an output register plus one skid entry decouple the two sides; req_stall
// rises only while the skid entry is full.
// synchronous active-high reset: pattern idle, registers at defaults, no result.

module buzzer_pattern_sequencer_unit #(
   parameter int TIME_WIDTH = bps_pkg::TIME_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_command,
   input  logic [2:0]                           req_pattern,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_sound_enable,
   output logic                                 rsp_busy_res,
   input  logic                                 csr_write,
   input  logic [bps_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bps_pkg::REG_WIDTH-1:0]        csr_wdata
);

   localparam int CMP_W = (TIME_WIDTH > bps_pkg::REG_WIDTH) ? TIME_WIDTH : bps_pkg::REG_WIDTH;

   // configuration registers
   logic [bps_pkg::REG_WIDTH-1:0] click_length_ff, alarm_half_ff, alarm_limit_ff;
   logic [bps_pkg::REG_WIDTH-1:0] done_length_ff, notify_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         click_length_ff <= bps_pkg::CLICK_LENGTH_RESET;
         alarm_half_ff   <= bps_pkg::ALARM_HALF_PERIOD_RESET;
         alarm_limit_ff  <= bps_pkg::ALARM_LIMIT_RESET;
         done_length_ff  <= bps_pkg::DONE_LENGTH_RESET;
         notify_step_ff  <= bps_pkg::NOTIFY_STEP_RESET;
      end else if (csr_write) begin
         case (bps_pkg::reg_index_type'(csr_index))
            bps_pkg::REG_CLICK_LENGTH:      click_length_ff <= csr_wdata;
            bps_pkg::REG_ALARM_HALF_PERIOD: alarm_half_ff   <= csr_wdata;
            bps_pkg::REG_ALARM_LIMIT:       alarm_limit_ff  <= csr_wdata;
            bps_pkg::REG_DONE_LENGTH:       done_length_ff  <= csr_wdata;
            bps_pkg::REG_NOTIFY_STEP:       notify_step_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pattern state
   logic                  running_ff, running_in;
   bps_pkg::pattern_type  pattern_ff, pattern_in;
   logic [TIME_WIDTH-1:0] since_start_ff, since_start_in;
   logic [TIME_WIDTH-1:0] since_toggle_ff, since_toggle_in;
   logic                  tone_ff, tone_in;
   bps_pkg::phase_type    phase_ff, phase_in;

   // output register and skid entry
   logic                  out_valid_ff, out_valid_in;
   bps_pkg::result_type   out_data_ff, out_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   bps_pkg::result_type   skid_data_ff, skid_data_in;

   logic                  accept;
   logic                  out_free;
   logic [TIME_WIDTH-1:0] start_bump, toggle_bump;
   logic [CMP_W-1:0]      start_x, toggle_x;
   bps_pkg::result_type   result;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // saturating elapsed counters
   assign start_bump  = (since_start_ff == '1) ? since_start_ff
                                               : since_start_ff + TIME_WIDTH'(1);
   assign toggle_bump = (since_toggle_ff == '1) ? since_toggle_ff
                                                : since_toggle_ff + TIME_WIDTH'(1);
   assign start_x  = CMP_W'(start_bump);
   assign toggle_x = CMP_W'(toggle_bump);

   always_comb begin
      running_in      = running_ff;
      pattern_in      = pattern_ff;
      since_start_in  = since_start_ff;
      since_toggle_in = since_toggle_ff;
      tone_in         = tone_ff;
      phase_in        = phase_ff;
      if (accept) begin
         case (bps_pkg::command_type'(req_command))
            bps_pkg::CMD_TICK: begin
               if (running_ff) begin
                  since_start_in  = start_bump;
                  since_toggle_in = toggle_bump;
                  case (pattern_ff)
                     bps_pkg::PAT_CLICK: begin
                        if (toggle_x >= CMP_W'(click_length_ff)) begin
                           running_in = 1'b0;
                           tone_in    = 1'b0;
                           pattern_in = bps_pkg::PAT_OFF;
                        end
                     end
                     bps_pkg::PAT_ALARM: begin
                        if (toggle_x >= CMP_W'(alarm_half_ff)) begin
                           tone_in         = !tone_ff;
                           since_toggle_in = '0;
                        end
                        // limit stop wins over a toggle on the same tick
                        if (start_x >= CMP_W'(alarm_limit_ff)) begin
                           running_in = 1'b0;
                           tone_in    = 1'b0;
                           pattern_in = bps_pkg::PAT_OFF;
                        end
                     end
                     bps_pkg::PAT_DONE: begin
                        if (start_x >= CMP_W'(done_length_ff)) begin
                           running_in = 1'b0;
                           tone_in    = 1'b0;
                           pattern_in = bps_pkg::PAT_OFF;
                        end
                     end
                     bps_pkg::PAT_NOTIFY: begin
                        case (phase_ff)
                           bps_pkg::PH_FIRST: begin
                              if (toggle_x >= CMP_W'(notify_step_ff)) begin
                                 tone_in         = 1'b0;
                                 phase_in        = bps_pkg::PH_GAP;
                                 since_toggle_in = '0;
                              end
                           end
                           bps_pkg::PH_GAP: begin
                              if (toggle_x >= CMP_W'(notify_step_ff)) begin
                                 tone_in         = 1'b1;
                                 phase_in        = bps_pkg::PH_SECOND;
                                 since_toggle_in = '0;
                              end
                           end
                           bps_pkg::PH_SECOND: begin
                              if (toggle_x >= CMP_W'(notify_step_ff)) begin
                                 running_in = 1'b0;
                                 tone_in    = 1'b0;
                                 pattern_in = bps_pkg::PAT_OFF;
                              end
                           end
                           default: begin
                              running_in = 1'b0;
                              tone_in    = 1'b0;
                              pattern_in = bps_pkg::PAT_OFF;
                           end
                        endcase
                     end
                     default: begin
                        running_in = 1'b0;
                        tone_in    = 1'b0;
                        pattern_in = bps_pkg::PAT_OFF;
                     end
                  endcase
               end
            end
            bps_pkg::CMD_PLAY: begin
               // off and undefined patterns act as stop
               if (req_pattern >= 3'(bps_pkg::PAT_CLICK) &&
                   req_pattern <= 3'(bps_pkg::PAT_NOTIFY)) begin
                  pattern_in      = bps_pkg::pattern_type'(req_pattern);
                  running_in      = 1'b1;
                  since_start_in  = '0;
                  since_toggle_in = '0;
                  phase_in        = bps_pkg::PH_FIRST;
                  tone_in         = 1'b1;
               end else begin
                  running_in = 1'b0;
                  tone_in    = 1'b0;
                  pattern_in = bps_pkg::PAT_OFF;
               end
            end
            bps_pkg::CMD_STOP: begin
               running_in = 1'b0;
               tone_in    = 1'b0;
               pattern_in = bps_pkg::PAT_OFF;
            end
            default: ;
         endcase
      end
   end

   assign result.sound_enable = tone_in;
   assign result.busy_res     = running_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         // output beat is held, park the new result
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff      <= 1'b0;
         pattern_ff      <= bps_pkg::PAT_OFF;
         since_start_ff  <= '0;
         since_toggle_ff <= '0;
         tone_ff         <= 1'b0;
         phase_ff        <= bps_pkg::PH_FIRST;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         running_ff      <= running_in;
         pattern_ff      <= pattern_in;
         since_start_ff  <= since_start_in;
         since_toggle_ff <= since_toggle_in;
         tone_ff         <= tone_in;
         phase_ff        <= phase_in;
         out_valid_ff    <= out_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sound_enable = out_data_ff.sound_enable;
   assign rsp_busy_res     = out_data_ff.busy_res;

   `BPS_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `BPS_ASSERT_NOW(a_tone_only_running, clock, reset, tone_ff, running_ff)
   `BPS_ASSERT_NEXT(a_stop_halts, clock, reset,
      accept && req_command == 2'(bps_pkg::CMD_STOP), !running_ff && !tone_ff)
   `BPS_ASSERT_NEXT(a_accept_gives_beat, clock, reset, accept, out_valid_ff)

endmodule

// File: verif/bps_checker.sv
`timescale 1ns / 1ps

// watches the request, result and register ports, tracks the tone state on its own
// and compares every result beat with the oldest prediction
module bps_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [1:0]                           req_command,
   input  logic [2:0]                           req_pattern,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic                                 rsp_sound_enable,
   input  logic                                 rsp_busy_res,
   input  logic                                 csr_write,
   input  logic [bps_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bps_pkg::REG_WIDTH-1:0]        csr_wdata,
   output int                                   fail_count,
   output int                                   pending_results,
   output int                                   results_checked
);

   logic [bps_pkg::REG_WIDTH-1:0]  click_len;
   logic [bps_pkg::REG_WIDTH-1:0]  half_period;
   logic [bps_pkg::REG_WIDTH-1:0]  alarm_stop;
   logic [bps_pkg::REG_WIDTH-1:0]  done_len;
   logic [bps_pkg::REG_WIDTH-1:0]  step_len;

   logic                           playing;
   bps_pkg::pattern_type           pattern_now;
   logic [bps_pkg::TIME_WIDTH-1:0] elapsed_total;
   logic [bps_pkg::TIME_WIDTH-1:0] elapsed_step;
   logic                           buzzer_on;
   bps_pkg::phase_type             notify_phase;

   bps_pkg::result_type            expected_tones[$];

   task automatic report_mismatch(input string what, input logic got, input logic want);
      $display("mismatch at %0t: %s got %b expected %b", $time, what, got, want);
      fail_count++;
   endtask

   task automatic stop_tone();
      buzzer_on   = 1'b0;
      playing     = 1'b0;
      pattern_now = bps_pkg::PAT_OFF;
   endtask

   task automatic start_tone(input logic [2:0] pat);
      if (pat < bps_pkg::PAT_CLICK || pat > bps_pkg::PAT_NOTIFY) begin
         stop_tone();
      end else begin
         pattern_now   = bps_pkg::pattern_type'(pat);
         playing       = 1'b1;
         elapsed_total = '0;
         elapsed_step  = '0;
         notify_phase  = bps_pkg::PH_FIRST;
         buzzer_on     = 1'b1;
      end
   endtask

   task automatic tick_tone();
      if (playing) begin
         // both counters stick at all ones
         if (elapsed_total != '1) elapsed_total = elapsed_total + 1'b1;
         if (elapsed_step != '1) elapsed_step = elapsed_step + 1'b1;
         case (pattern_now)
            bps_pkg::PAT_CLICK: begin
               if (elapsed_step >= click_len) stop_tone();
            end
            bps_pkg::PAT_ALARM: begin
               // toggle first, then the overall limit may still end it
               if (elapsed_step >= half_period) begin
                  buzzer_on    = !buzzer_on;
                  elapsed_step = '0;
               end
               if (elapsed_total >= alarm_stop) stop_tone();
            end
            bps_pkg::PAT_DONE: begin
               if (elapsed_total >= done_len) stop_tone();
            end
            bps_pkg::PAT_NOTIFY: begin
               case (notify_phase)
                  bps_pkg::PH_FIRST: begin
                     if (elapsed_step >= step_len) begin
                        buzzer_on    = 1'b0;
                        notify_phase = bps_pkg::PH_GAP;
                        elapsed_step = '0;
                     end
                  end
                  bps_pkg::PH_GAP: begin
                     if (elapsed_step >= step_len) begin
                        buzzer_on    = 1'b1;
                        notify_phase = bps_pkg::PH_SECOND;
                        elapsed_step = '0;
                     end
                  end
                  bps_pkg::PH_SECOND: begin
                     if (elapsed_step >= step_len) stop_tone();
                  end
                  default: stop_tone();
               endcase
            end
            default: stop_tone();
         endcase
      end
   endtask

   always @(posedge clock) begin
      bps_pkg::result_type want;
      if (reset) begin
         click_len     = bps_pkg::CLICK_LENGTH_RESET;
         half_period   = bps_pkg::ALARM_HALF_PERIOD_RESET;
         alarm_stop    = bps_pkg::ALARM_LIMIT_RESET;
         done_len      = bps_pkg::DONE_LENGTH_RESET;
         step_len      = bps_pkg::NOTIFY_STEP_RESET;
         playing       = 1'b0;
         pattern_now   = bps_pkg::PAT_OFF;
         elapsed_total = '0;
         elapsed_step  = '0;
         buzzer_on     = 1'b0;
         notify_phase  = bps_pkg::PH_FIRST;
         expected_tones.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               bps_pkg::REG_CLICK_LENGTH:      click_len   = csr_wdata;
               bps_pkg::REG_ALARM_HALF_PERIOD: half_period = csr_wdata;
               bps_pkg::REG_ALARM_LIMIT:       alarm_stop  = csr_wdata;
               bps_pkg::REG_DONE_LENGTH:       done_len    = csr_wdata;
               bps_pkg::REG_NOTIFY_STEP:       step_len    = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_tones.size() == 0) begin
               report_mismatch("unexpected result beat, sound_enable", rsp_sound_enable, 1'bx);
            end else begin
               want = expected_tones.pop_front();
               if (rsp_sound_enable !== want.sound_enable)
                  report_mismatch("sound_enable", rsp_sound_enable, want.sound_enable);
               if (rsp_busy_res !== want.busy_res)
                  report_mismatch("busy_res", rsp_busy_res, want.busy_res);
               results_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            case (req_command)
               bps_pkg::CMD_TICK: tick_tone();
               bps_pkg::CMD_PLAY: start_tone(req_pattern);
               bps_pkg::CMD_STOP: stop_tone();
               default: ;
            endcase
            want.sound_enable = buzzer_on;
            want.busy_res     = playing;
            expected_tones.push_back(want);
         end
      end
      pending_results = expected_tones.size();
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int          HALF_PERIOD    = 5;
   localparam int          RESET_CYCLES   = 8;
   localparam int          NUM_PHASES     = 9;
   localparam int          BEATS_PER_PHASE = 190;
   localparam int          DRAIN_CYCLES   = 10;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          REG_W          = bps_pkg::REG_WIDTH;
   localparam int          IDX_W          = bps_pkg::CSR_INDEX_WIDTH;
   localparam logic [1:0]  CMD_UNUSED       = 2'd3;
   localparam logic [2:0]  PAT_UNDEF_FIRST  = 3'd5;
   localparam logic [2:0]  PAT_UNDEF_MID    = 3'd6;
   localparam logic [2:0]  PAT_UNDEF_LAST   = 3'd7;
   localparam logic [2:0]  REG_UNUSED_FIRST = 3'd5;
   localparam logic [2:0]  REG_UNUSED_LAST  = 3'd7;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [1:0]                 req_command;
   logic [2:0]                 req_pattern;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_sound_enable;
   logic                       rsp_busy_res;
   logic                       csr_write;
   logic [IDX_W-1:0]           csr_index;
   logic [REG_W-1:0]           csr_wdata;

   int fail_count;
   int pending_results;
   int results_checked;
   int sender_idle;
   int receiver_idle;
   int beats_sent;
   int idle_cycles;

   buzzer_pattern_sequencer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_pattern      (req_pattern),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sound_enable (rsp_sound_enable),
      .rsp_busy_res     (rsp_busy_res),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   bps_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_pattern      (req_pattern),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sound_enable (rsp_sound_enable),
      .rsp_busy_res     (rsp_busy_res),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_results  (pending_results),
      .results_checked  (results_checked)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_idle);
   end

   // a stretch without a beat on either channel ends the run once the idle count reaches the watchdog limit
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_results);
            $display("** buzzer_pattern_sequencer_unit: FAILED **");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [1:0] cmd, input logic [2:0] pat);
      while ($urandom_range(0, 99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_pattern <= pat;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic send_random_item();
      int         roll;
      logic [1:0] cmd;
      logic [2:0] pat;
      roll = $urandom_range(0, 99);
      pat  = 3'($urandom_range(bps_pkg::PAT_CLICK, bps_pkg::PAT_NOTIFY));
      if (roll < 76)      cmd = bps_pkg::CMD_TICK;
      else if (roll < 90) cmd = bps_pkg::CMD_PLAY;
      else if (roll < 95) cmd = bps_pkg::CMD_STOP;
      else                cmd = CMD_UNUSED;
      // most plays start a real pattern, the rest draw any code, off and undefined codes included
      if (cmd != bps_pkg::CMD_PLAY || $urandom_range(0, 99) < 12)
         pat = 3'($urandom_range(0, PAT_UNDEF_LAST));
      send_item(cmd, pat);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx,
                            input logic [REG_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (pending_results != 0);
      @(posedge clock);
   endtask

   initial begin
      logic [REG_W-1:0] setting [5];
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_command   = bps_pkg::CMD_TICK;
      req_pattern   = bps_pkg::PAT_OFF;
      csr_write     = 1'b0;
      csr_index     = bps_pkg::REG_CLICK_LENGTH;
      csr_wdata     = '0;
      sender_idle   = 26;
      receiver_idle = 56;
      beats_sent    = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed beats under the reset register values
      send_item(bps_pkg::CMD_TICK, bps_pkg::PAT_OFF);
      send_item(CMD_UNUSED, PAT_UNDEF_LAST);
      send_item(bps_pkg::CMD_PLAY, bps_pkg::PAT_CLICK);
      send_item(bps_pkg::CMD_TICK, bps_pkg::PAT_OFF);
      send_item(bps_pkg::CMD_PLAY, bps_pkg::PAT_ALARM);
      send_item(bps_pkg::CMD_TICK, bps_pkg::PAT_OFF);
      send_item(bps_pkg::CMD_PLAY, bps_pkg::PAT_DONE);
      send_item(bps_pkg::CMD_PLAY, bps_pkg::PAT_NOTIFY);
      send_item(bps_pkg::CMD_TICK, bps_pkg::PAT_OFF);
      send_item(bps_pkg::CMD_PLAY, PAT_UNDEF_FIRST);
      send_item(bps_pkg::CMD_PLAY, bps_pkg::PAT_NOTIFY);
      send_item(bps_pkg::CMD_PLAY, PAT_UNDEF_MID);
      send_item(bps_pkg::CMD_PLAY, bps_pkg::PAT_ALARM);
      send_item(bps_pkg::CMD_PLAY, PAT_UNDEF_LAST);
      send_item(bps_pkg::CMD_PLAY, bps_pkg::PAT_CLICK);
      send_item(CMD_UNUSED, bps_pkg::PAT_OFF);
      send_item(bps_pkg::CMD_PLAY, bps_pkg::PAT_OFF);
      send_item(bps_pkg::CMD_STOP, bps_pkg::PAT_OFF);
      send_item(bps_pkg::CMD_PLAY, bps_pkg::PAT_DONE);
      send_item(bps_pkg::CMD_STOP, PAT_UNDEF_LAST);
      send_item(bps_pkg::CMD_TICK, bps_pkg::PAT_NOTIFY);
      req_valid <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == 3) begin
            sender_idle   = 56;
            receiver_idle = 26;
         end else if (ph == 6) begin
            sender_idle   = 0;
            receiver_idle = 0;
         end
         case (ph)
            0: setting = '{5{16'd0}};
            1: setting = '{5{16'd1}};
            // alarm toggle and limit land on the same tick
            2: setting = '{16'd4, 16'd3, 16'd6, 16'd7, 16'd3};
            4: setting = '{5{16'hFFFF}};
            7: setting = '{16'd2, 16'd1, 16'hFFFF, 16'd3, 16'd1};
            default: begin
               for (int r = 0; r < 5; r++)
                  setting[r] = (ph == 6) ? REG_W'($urandom_range(0, 8))
                                         : REG_W'($urandom_range(1, 4 * ph));
            end
         endcase
         wait_drained();
         write_reg(bps_pkg::REG_CLICK_LENGTH, setting[0]);
         write_reg(bps_pkg::REG_ALARM_HALF_PERIOD, setting[1]);
         write_reg(bps_pkg::REG_ALARM_LIMIT, setting[2]);
         write_reg(bps_pkg::REG_DONE_LENGTH, setting[3]);
         write_reg(bps_pkg::REG_NOTIFY_STEP, setting[4]);
         // writes past the last register must leave everything alone
         write_reg(IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                   REG_W'($urandom));
         csr_write <= 1'b0;
         repeat (BEATS_PER_PHASE) send_random_item();
         req_valid <= 1'b0;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d request beats across %0d register settings and three idle mixes",
               beats_sent, NUM_PHASES + 1);
      $display("checked %0d result beats, %0d mismatches", results_checked, fail_count);
      if (fail_count == 0 && pending_results == 0) begin
         $display("** buzzer_pattern_sequencer_unit: PASSED **");
      end else begin
         $display("** buzzer_pattern_sequencer_unit: FAILED **");
      end
      $finish;
   end

endmodule
